// ----- design/sqg_pkg.sv -----
package sqg_pkg;

	localparam int DataW = 16;
	localparam int MagShift = 9;
	localparam int AvgW = DataW + MagShift;
	localparam int MulAW = AvgW;
	localparam int MulBW = 17;
	localparam int ProdW = MulAW + MulBW;
	localparam int CntW = $clog2(MulBW + 1);
	localparam int CoefFrac = 16;
	localparam int HystW = 12;
	localparam int HystShift = 24;
	localparam int CmpW = ProdW + 1;
	localparam int AddrW = 5;
	localparam int ApbW = 32;

	typedef enum logic [2:0] {
		REG_MODE = 3'd0,
		REG_NOISE_THRESHOLD = 3'd1,
		REG_LEVEL_THRESHOLD = 3'd2,
		REG_HOLD_PERIOD = 3'd3,
		REG_AVERAGE_COEFF = 3'd4,
		REG_NOISE_HYSTERESIS = 3'd5
	} sqg_reg_t;

	localparam logic [16:0] NoiseThresholdRst = 17'd65536;
	localparam logic [15:0] LevelThresholdRst = 16'd0;
	localparam logic [15:0] HoldPeriodRst = 16'd1024;
	localparam logic [16:0] AverageCoeffRst = 17'd137;
	localparam logic [HystW-1:0] NoiseHysteresisRst = 12'd66;

	typedef struct packed {
		logic signed [DataW-1:0] sample;
		logic [DataW-1:0] high_band_mag;
		logic [DataW-1:0] low_band_mag;
		logic [DataW-1:0] carrier_level;
	} sqg_item_t;

	typedef struct packed {
		logic signed [DataW-1:0] sample_out;
		logic suppressed;
		logic state_changed;
	} sqg_result_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_H_START,
		ST_H_RUN,
		ST_L_START,
		ST_L_RUN,
		ST_DECIDE,
		ST_P_RUN,
		ST_CMP,
		ST_EMIT
	} sqg_state_t;

	typedef enum logic [1:0] {
		MUL_SEL_HIGH,
		MUL_SEL_LOW,
		MUL_SEL_PROD
	} sqg_mul_sel_t;

	typedef struct packed {
		logic item_take;
		logic mode;
		logic coeff_full;
		logic decide;
		logic thr_lt_hyst;
		logic mul_busy;
		logic out_free;
	} sqg_stat_t;

	typedef struct packed {
		logic item_ready;
		logic mul_load;
		sqg_mul_sel_t mul_sel;
		logic avg_direct;
		logic upd_high;
		logic upd_low;
		logic set_level;
		logic set_force;
		logic cmp_prep;
		logic cmp_apply;
		logic emit;
	} sqg_ctl_t;

endpackage

// ----- design/sqg_serial_mul.sv -----
module sqg_serial_mul (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        load,
	input  logic [sqg_pkg::MulAW-1:0]   a,
	input  logic [sqg_pkg::MulBW-1:0]   b,
	output logic                        busy,
	output logic [sqg_pkg::ProdW-1:0]   prod
);

	logic                       busy_q;
	logic [sqg_pkg::CntW-1:0]   cnt_q;
	logic [sqg_pkg::MulAW-1:0]  a_q;
	logic [sqg_pkg::MulAW-1:0]  hi_q;
	logic [sqg_pkg::MulBW-1:0]  lo_q;
	logic [sqg_pkg::MulAW:0]    sum;

	// one multiplier bit per cycle, lsb first
	assign sum = {1'b0, hi_q} + (lo_q[0] ? {1'b0, a_q} : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (load) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == sqg_pkg::CntW'(sqg_pkg::MulBW - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			a_q  <= a;
			hi_q <= '0;
			lo_q <= b;
		end else if (busy_q) begin
			hi_q <= sum[sqg_pkg::MulAW:1];
			lo_q <= {sum[0], lo_q[sqg_pkg::MulBW-1:1]};
		end
	end

	assign busy = busy_q;
	assign prod = {hi_q, lo_q};

endmodule

// ----- design/sqg_ctrl.sv -----
module sqg_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  sqg_pkg::sqg_stat_t  stat,
	output sqg_pkg::sqg_ctl_t   ctl
);

	sqg_pkg::sqg_state_t state_q;
	sqg_pkg::sqg_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sqg_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			sqg_pkg::ST_IDLE: begin
				if (stat.item_take) state_d = sqg_pkg::ST_H_START;
			end
			sqg_pkg::ST_H_START: begin
				if (stat.mode || stat.coeff_full) state_d = sqg_pkg::ST_DECIDE;
				else state_d = sqg_pkg::ST_H_RUN;
			end
			sqg_pkg::ST_H_RUN: begin
				if (!stat.mul_busy) state_d = sqg_pkg::ST_L_START;
			end
			sqg_pkg::ST_L_START: begin
				state_d = sqg_pkg::ST_L_RUN;
			end
			sqg_pkg::ST_L_RUN: begin
				if (!stat.mul_busy) state_d = sqg_pkg::ST_DECIDE;
			end
			sqg_pkg::ST_DECIDE: begin
				if (!stat.decide || stat.mode || stat.thr_lt_hyst) state_d = sqg_pkg::ST_EMIT;
				else state_d = sqg_pkg::ST_P_RUN;
			end
			sqg_pkg::ST_P_RUN: begin
				if (!stat.mul_busy) state_d = sqg_pkg::ST_CMP;
			end
			sqg_pkg::ST_CMP: begin
				state_d = sqg_pkg::ST_EMIT;
			end
			sqg_pkg::ST_EMIT: begin
				if (stat.out_free) state_d = sqg_pkg::ST_IDLE;
			end
			default: begin
				state_d = sqg_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		ctl = '0;
		ctl.mul_sel = sqg_pkg::MUL_SEL_HIGH;
		case (state_q)
			sqg_pkg::ST_IDLE: begin
				ctl.item_ready = 1'b1;
			end
			sqg_pkg::ST_H_START: begin
				if (!stat.mode) begin
					if (stat.coeff_full) ctl.avg_direct = 1'b1;
					else ctl.mul_load = 1'b1;
				end
			end
			sqg_pkg::ST_H_RUN: begin
				ctl.upd_high = !stat.mul_busy;
			end
			sqg_pkg::ST_L_START: begin
				ctl.mul_load = 1'b1;
				ctl.mul_sel = sqg_pkg::MUL_SEL_LOW;
			end
			sqg_pkg::ST_L_RUN: begin
				ctl.upd_low = !stat.mul_busy;
			end
			sqg_pkg::ST_DECIDE: begin
				if (stat.decide) begin
					if (stat.mode) begin
						ctl.set_level = 1'b1;
					end else if (stat.thr_lt_hyst) begin
						ctl.set_force = 1'b1;
					end else begin
						ctl.mul_load = 1'b1;
						ctl.mul_sel = sqg_pkg::MUL_SEL_PROD;
					end
				end
			end
			sqg_pkg::ST_P_RUN: begin
				ctl.cmp_prep = !stat.mul_busy;
			end
			sqg_pkg::ST_CMP: begin
				ctl.cmp_apply = 1'b1;
			end
			sqg_pkg::ST_EMIT: begin
				ctl.emit = stat.out_free;
			end
			default: begin
				ctl.item_ready = 1'b0;
			end
		endcase
	end

endmodule

// ----- design/audio_squelch_gate.sv -----
// Squelch gate for an audio stream, one sample per transaction, with the band
// magnitudes and carrier level alongside. Level mode leaves the band averages
// alone. In noise mode the two band averages are updated one after the other
// on a bit-serial 25x17 multiplier, or loaded directly with average_coeff at
// one or more; on a sample that ends a hold period the same multiplier forms
// the threshold product unless noise_threshold is below noise_hysteresis.
// Results wait in an output register; the next sample is taken meanwhile.
module audio_squelch_gate (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          item_valid,
	output logic                          item_stall,
	input  sqg_pkg::sqg_item_t            item,
	output logic                          result_valid,
	input  logic                          result_stall,
	output sqg_pkg::sqg_result_t          result,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [sqg_pkg::AddrW-1:0]     paddr,
	input  logic [sqg_pkg::ApbW-1:0]      pwdata,
	output logic [sqg_pkg::ApbW-1:0]      prdata,
	output logic                          pready
);

	logic                            mode_q;
	logic [16:0]                     noise_threshold_q;
	logic [15:0]                     level_threshold_q;
	logic [15:0]                     hold_period_q;
	logic [16:0]                     average_coeff_q;
	logic [sqg_pkg::HystW-1:0]       noise_hysteresis_q;

	logic [sqg_pkg::AvgW-1:0]        high_avg_q;
	logic [sqg_pkg::AvgW-1:0]        low_avg_q;
	logic [15:0]                     hold_q;
	logic                            decide_q;
	logic                            suppress_q;
	logic                            reported_q;
	logic                            dir_q;
	sqg_pkg::sqg_item_t              item_q;
	logic [sqg_pkg::CmpW-1:0]        hy_q;
	logic [sqg_pkg::CmpW-1:0]        py_q;
	logic                            result_valid_q;
	sqg_pkg::sqg_result_t            result_q;

	sqg_pkg::sqg_stat_t              stat;
	sqg_pkg::sqg_ctl_t               ctl;
	sqg_pkg::sqg_reg_t               reg_idx;

	logic                            cfg_wr;
	logic                            accept;
	logic [15:0]                     hold_inc;
	logic [sqg_pkg::AvgW-1:0]        x_high;
	logic [sqg_pkg::AvgW-1:0]        x_low;
	logic [sqg_pkg::AvgW-1:0]        x_sel;
	logic [sqg_pkg::AvgW-1:0]        avg_sel;
	logic                            x_ge;
	logic                            mul_busy;
	logic [sqg_pkg::MulAW-1:0]       mul_a;
	logic [sqg_pkg::MulBW-1:0]       mul_b;
	logic [sqg_pkg::ProdW-1:0]       prod;
	logic [sqg_pkg::AvgW-1:0]        step;
	logic [sqg_pkg::AvgW-1:0]        avg_next;
	logic [sqg_pkg::CmpW-1:0]        h_ext;
	logic [sqg_pkg::CmpW-1:0]        y_ext;
	logic [sqg_pkg::CmpW-1:0]        p_ext;

	// configuration port
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign reg_idx = sqg_pkg::sqg_reg_t'(paddr[sqg_pkg::AddrW-1:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q             <= 1'b0;
			noise_threshold_q  <= sqg_pkg::NoiseThresholdRst;
			level_threshold_q  <= sqg_pkg::LevelThresholdRst;
			hold_period_q      <= sqg_pkg::HoldPeriodRst;
			average_coeff_q    <= sqg_pkg::AverageCoeffRst;
			noise_hysteresis_q <= sqg_pkg::NoiseHysteresisRst;
		end else if (cfg_wr) begin
			case (reg_idx)
				sqg_pkg::REG_MODE:             mode_q             <= pwdata[0];
				sqg_pkg::REG_NOISE_THRESHOLD:  noise_threshold_q  <= pwdata[16:0];
				sqg_pkg::REG_LEVEL_THRESHOLD:  level_threshold_q  <= pwdata[15:0];
				sqg_pkg::REG_HOLD_PERIOD:      hold_period_q      <= pwdata[15:0];
				sqg_pkg::REG_AVERAGE_COEFF:    average_coeff_q    <= pwdata[16:0];
				sqg_pkg::REG_NOISE_HYSTERESIS:
					noise_hysteresis_q <= pwdata[sqg_pkg::HystW-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			sqg_pkg::REG_MODE:             prdata = {31'd0, mode_q};
			sqg_pkg::REG_NOISE_THRESHOLD:  prdata = {15'd0, noise_threshold_q};
			sqg_pkg::REG_LEVEL_THRESHOLD:  prdata = {16'd0, level_threshold_q};
			sqg_pkg::REG_HOLD_PERIOD:      prdata = {16'd0, hold_period_q};
			sqg_pkg::REG_AVERAGE_COEFF:    prdata = {15'd0, average_coeff_q};
			sqg_pkg::REG_NOISE_HYSTERESIS:
				prdata = {{(sqg_pkg::ApbW - sqg_pkg::HystW){1'b0}}, noise_hysteresis_q};
			default:                       prdata = '0;
		endcase
	end

	// control
	assign accept = item_valid && ctl.item_ready;
	assign item_stall = !ctl.item_ready;

	assign stat.item_take   = item_valid;
	assign stat.mode        = mode_q;
	assign stat.coeff_full  = average_coeff_q[16];
	assign stat.decide      = decide_q;
	assign stat.thr_lt_hyst = noise_threshold_q < {5'd0, noise_hysteresis_q};
	assign stat.mul_busy    = mul_busy;
	assign stat.out_free    = !result_valid_q || !result_stall;

	sqg_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.ctl    (ctl)
	);

	// averaging datapath
	assign x_high = {item_q.high_band_mag, {sqg_pkg::MagShift{1'b0}}};
	assign x_low  = {item_q.low_band_mag, {sqg_pkg::MagShift{1'b0}}};
	assign x_sel   = (ctl.mul_sel == sqg_pkg::MUL_SEL_LOW) ? x_low : x_high;
	assign avg_sel = (ctl.mul_sel == sqg_pkg::MUL_SEL_LOW) ? low_avg_q : high_avg_q;
	assign x_ge    = x_sel >= avg_sel;

	always_comb begin
		if (ctl.mul_sel == sqg_pkg::MUL_SEL_PROD) begin
			mul_a = low_avg_q;
			mul_b = noise_threshold_q;
		end else begin
			mul_a = x_ge ? (x_sel - avg_sel) : (avg_sel - x_sel);
			mul_b = average_coeff_q;
		end
	end

	sqg_serial_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (ctl.mul_load),
		.a      (mul_a),
		.b      (mul_b),
		.busy   (mul_busy),
		.prod   (prod)
	);

	assign step = prod[sqg_pkg::CoefFrac +: sqg_pkg::AvgW];

	always_comb begin
		if (ctl.upd_low) avg_next = dir_q ? (low_avg_q + step) : (low_avg_q - step);
		else avg_next = dir_q ? (high_avg_q + step) : (high_avg_q - step);
	end

	// threshold compare operands
	assign h_ext = {2'b00, high_avg_q, {sqg_pkg::CoefFrac{1'b0}}};
	assign y_ext = {{(sqg_pkg::CmpW - sqg_pkg::HystW - sqg_pkg::HystShift){1'b0}},
		noise_hysteresis_q, {sqg_pkg::HystShift{1'b0}}};
	assign p_ext = {1'b0, prod};

	assign hold_inc = hold_q + 16'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			high_avg_q <= '0;
			low_avg_q  <= '0;
			hold_q     <= '0;
			decide_q   <= 1'b0;
			suppress_q <= 1'b0;
			reported_q <= 1'b1;
		end else begin
			if (accept) begin
				decide_q <= hold_inc >= hold_period_q;
				hold_q   <= (hold_inc >= hold_period_q) ? 16'd0 : hold_inc;
			end
			if (ctl.avg_direct) begin
				high_avg_q <= x_high;
				low_avg_q  <= x_low;
			end
			if (ctl.upd_high) high_avg_q <= avg_next;
			if (ctl.upd_low) low_avg_q <= avg_next;
			if (ctl.set_level) suppress_q <= item_q.carrier_level < level_threshold_q;
			if (ctl.set_force) suppress_q <= 1'b1;
			if (ctl.cmp_apply) begin
				if (hy_q < p_ext) suppress_q <= 1'b0;
				else if (h_ext >= py_q) suppress_q <= 1'b1;
			end
			if (ctl.emit) reported_q <= suppress_q;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) item_q <= item;
		if (ctl.mul_load) dir_q <= x_ge;
		if (ctl.cmp_prep) begin
			hy_q <= h_ext + y_ext;
			py_q <= p_ext + y_ext;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (ctl.emit) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.emit) begin
			result_q.sample_out    <= suppress_q ? '0 : item_q.sample;
			result_q.suppressed    <= suppress_q;
			result_q.state_changed <= suppress_q != reported_q;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

`ifndef SYNTHESIS
	ap_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && !item_stall) |=> item_stall)
		else $error("sample taken while previous one still in work");

	ap_muted_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.suppressed) |-> (result.sample_out == '0))
		else $error("suppressed result carries nonzero audio");

	ap_mul_free: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.mul_load |-> !mul_busy)
		else $error("multiplier reloaded while running");

	ap_emit_valid: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.emit |=> result_valid)
		else $error("finished transaction not presented");
`endif

endmodule
